[src/stq_pkg.sv]
// Shared types, codes and constants of the per-slot token bucket queue.
package stq_pkg;

	// Default sizes of the slot table and of each slot's FIFO.
	localparam int SLOTS_DEF       = 16;
	localparam int QUEUE_DEPTH_DEF = 16;

	// Field widths of the input and result beats.
	localparam int CMD_W      = 2;
	localparam int SLOT_W     = 4;
	localparam int TIME_W     = 48;
	localparam int HDG_W      = 16;
	localparam int VEL_W      = 17;
	localparam int REF_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Shared multiply-accumulate unit widths.
	localparam int MAC_W = 18;
	localparam int ACC_W = 36;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LEAVE  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_QUEUED      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_HEADING = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_FAST    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DISPATCHED  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_TICK_DONE   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_CLEARED     = 3'd6;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BURST     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REFILL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QLIMIT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TOL       = 3'd4;

	// Register values after reset.
	localparam logic [15:0] BURST_RESET     = 16'd3000;
	localparam logic [9:0]  REFILL_RESET    = 10'd3;
	localparam logic [4:0]  QLIMIT_RESET    = 5'd10;
	localparam logic [15:0] MAX_SPEED_RESET = 16'd4000;
	localparam logic [12:0] TOL_RESET       = 13'd164;

	// One token in thousandths, and unit length in Q2.14.
	localparam logic [15:0]              MILLI_PER_TOKEN = 16'd1000;
	localparam logic signed [MAC_W-1:0] UNIT_Q14        = 18'sd16384;

	typedef struct packed {
		logic [15:0] burst;
		logic [9:0]  refill;
		logic [4:0]  qlimit;
		logic [15:0] max_speed;
		logic [12:0] tol;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic clr;
	} mac_ctl_t;

endpackage

[src/stq_cfg.sv]
// Configuration register file of the per-slot token bucket queue.
module stq_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [stq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stq_pkg::CFG_DATA_W-1:0] cfg_data,
	output stq_pkg::cfg_t                  cfg
);
	import stq_pkg::*;

	cfg_t cfg_q;

	// Decode the index and take the low bits of the write data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.burst     <= BURST_RESET;
			cfg_q.refill    <= REFILL_RESET;
			cfg_q.qlimit    <= QLIMIT_RESET;
			cfg_q.max_speed <= MAX_SPEED_RESET;
			cfg_q.tol       <= TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BURST:     cfg_q.burst     <= cfg_data[15:0];
				CFG_REFILL:    cfg_q.refill    <= cfg_data[9:0];
				CFG_QLIMIT:    cfg_q.qlimit    <= cfg_data[4:0];
				CFG_MAX_SPEED: cfg_q.max_speed <= cfg_data[15:0];
				CFG_TOL:       cfg_q.tol       <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/stq_mac.sv]
// Shared signed multiply-accumulate unit used for every squared length and refill.
module stq_mac (
	input  logic                              clk,
	input  stq_pkg::mac_ctl_t                 ctl,
	input  logic signed [stq_pkg::MAC_W-1:0]  a,
	input  logic signed [stq_pkg::MAC_W-1:0]  b,
	output logic signed [stq_pkg::ACC_W-1:0]  acc
);
	import stq_pkg::*;

	logic signed [ACC_W-1:0] prod;
	logic signed [ACC_W-1:0] acc_q;

	assign prod = a * b;

	// The accumulator either restarts from the product or adds it on.
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= (ctl.clr ? '0 : acc_q) + prod;
		end
	end

	assign acc = acc_q;

endmodule

[src/per_slot_token_bucket_queue.sv]
// Top level of the per-slot token bucket queue: sequencer, slot table and FIFO store.
// An arrival is checked by one shared multiply-accumulate unit in ten steps and answers
// with a single beat. A tick visits every slot in turn: an empty slot is read and tested,
// a slot whose stamp is unset is read, tested and has a token taken, and a slot that
// refills goes through read, test and load level, add refill, clamp and take token; each
// dispatch emits a result beat, and the tick closes with a final tick-done beat. The input
// stalls while an item is being worked on; a result beat that waits in the output register
// does not hold off the next item. The slot table and the FIFO store are single-port
// memories with registered reads; the slot table uses one valid bit per slot in place of
// a clearing pass, and the FIFO store is never cleared.
module per_slot_token_bucket_queue #(
	parameter int SLOTS       = stq_pkg::SLOTS_DEF,
	parameter int QUEUE_DEPTH = stq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [stq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [stq_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [stq_pkg::CMD_W-1:0]            command,
	input  logic [stq_pkg::SLOT_W-1:0]           slot,
	input  logic [stq_pkg::TIME_W-1:0]           now_ms,
	input  logic signed [stq_pkg::HDG_W-1:0]     heading_x,
	input  logic signed [stq_pkg::HDG_W-1:0]     heading_y,
	input  logic signed [stq_pkg::HDG_W-1:0]     heading_z,
	input  logic signed [stq_pkg::VEL_W-1:0]     velocity_x,
	input  logic signed [stq_pkg::VEL_W-1:0]     velocity_y,
	input  logic signed [stq_pkg::VEL_W-1:0]     velocity_z,
	input  logic [stq_pkg::REF_W-1:0]            request_ref,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [stq_pkg::STATUS_W-1:0]         status,
	output logic [stq_pkg::SLOT_W-1:0]           out_slot,
	output logic [stq_pkg::REF_W-1:0]            out_ref,
	output logic                                 last
);
	import stq_pkg::*;

	localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int AW   = (SLOTS * QUEUE_DEPTH > 1) ? $clog2(SLOTS * QUEUE_DEPTH) : 1;
	localparam int SRW  = ($clog2(SLOTS + 1) > SLOT_W) ? $clog2(SLOTS + 1) : SLOT_W;
	localparam int LIMW = (CW > 5) ? CW : 5;

	// Steps of the arrival check on the shared unit.
	localparam logic [3:0] STEP_HX  = 4'd0;
	localparam logic [3:0] STEP_HY  = 4'd1;
	localparam logic [3:0] STEP_HZ  = 4'd2;
	localparam logic [3:0] STEP_LO  = 4'd3;
	localparam logic [3:0] STEP_HI  = 4'd4;
	localparam logic [3:0] STEP_MS  = 4'd5;
	localparam logic [3:0] STEP_VX  = 4'd6;
	localparam logic [3:0] STEP_VY  = 4'd7;
	localparam logic [3:0] STEP_VZ  = 4'd8;
	localparam logic [3:0] STEP_CMP = 4'd9;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_A_CHK   = 10'b00_0000_0010,
		S_A_DEC   = 10'b00_0000_0100,
		S_T_RD    = 10'b00_0000_1000,
		S_T_CHK   = 10'b00_0001_0000,
		S_T_REF   = 10'b00_0010_0000,
		S_T_CLAMP = 10'b00_0100_0000,
		S_T_TOK   = 10'b00_1000_0000,
		S_EMIT    = 10'b01_0000_0000,
		S_SPARE   = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		logic [15:0]     bucket;
		logic [47:0]     stamp;
		logic [HW-1:0]   head;
		logic [CW-1:0]   count;
	} slot_ent_t;

	cfg_t cfg;

	state_t state_q, state_d;
	logic [3:0]    step_q;
	logic [SW-1:0] scan_q;
	logic          do_adv;
	logic          last_slot;
	logic          in_acc;

	// Captured input beat.
	logic [SLOT_W-1:0]      slot_q;
	logic [TIME_W-1:0]      now_q;
	logic [REF_W-1:0]       ref_q;
	logic signed [MAC_W-1:0] hx_q, hy_q, hz_q, vx_q, vy_q, vz_q;

	// Shared unit and comparator.
	mac_ctl_t                mac_ctl;
	logic signed [MAC_W-1:0] mac_a, mac_b;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] hold_q;
	logic signed [ACC_W-1:0] cmp_x, cmp_y;
	logic                    cmp_gt;
	logic signed [MAC_W-1:0] lo_v, hi_v, ms_v;
	logic                    bad_q, fast_q;

	// Tick datapath.
	logic [15:0]     level_q;
	logic [16:0]     el_q;
	logic [47:0]     elapsed;
	logic [16:0]     el_c;
	logic            tok;

	// Slot table.
	slot_ent_t       slot_mem [SLOTS];
	slot_ent_t       sm_rd_q;
	logic            sm_rd_vld_q;
	logic [SLOTS-1:0] slot_vld_q;
	logic            sm_re, sm_we;
	logic [SW-1:0]   sm_raddr, sm_waddr;
	slot_ent_t       sm_wdata;
	slot_ent_t       ent, ent_reset;

	// FIFO store.
	logic [REF_W-1:0] q_mem [SLOTS * QUEUE_DEPTH];
	logic [REF_W-1:0] q_rd_q;
	logic             q_re, q_we;
	logic [AW-1:0]    q_raddr, q_waddr;

	// Arrival decision.
	logic [SW-1:0]    slot_idx_q;
	logic             in_range_q, in_range_in;
	logic [CW:0]      pos_sum;
	logic [HW-1:0]    pos;
	logic [HW-1:0]    head_inc;
	logic [LIMW-1:0]  lim;
	logic             full;
	logic [STATUS_W-1:0] arr_status;

	// Pending result and output register.
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic                res_last_q;
	logic                out_valid_q;
	logic                out_free;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [REF_W-1:0]    out_ref_q;
	logic                last_q;

	stq_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	stq_mac u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.a   (mac_a),
		.b   (mac_b),
		.acc (acc)
	);

	// Handshake on both sides.
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Heading bounds and speed limit as operands of the shared unit.
	assign lo_v = UNIT_Q14 - $signed(MAC_W'(cfg.tol));
	assign hi_v = UNIT_Q14 + $signed(MAC_W'(cfg.tol));
	assign ms_v = $signed(MAC_W'(cfg.max_speed));

	assign cmp_gt = cmp_x > cmp_y;

	// A slot that was never written reads as its reset contents.
	assign ent_reset = '{bucket: BURST_RESET, stamp: '0, head: '0, count: '0};
	assign ent       = sm_rd_vld_q ? sm_rd_q : ent_reset;

	// FIFO position arithmetic for the slot under work.
	assign slot_idx_q  = SW'(slot_q);
	assign in_range_q  = SRW'(slot_q) < SRW'(SLOTS);
	assign in_range_in = SRW'(slot) < SRW'(SLOTS);
	assign pos_sum     = (CW+1)'(ent.head) + (CW+1)'(ent.count);
	assign pos         = (pos_sum >= (CW+1)'(QUEUE_DEPTH)) ?
	                     HW'(pos_sum - (CW+1)'(QUEUE_DEPTH)) : HW'(pos_sum);
	assign head_inc    = (ent.head == HW'(QUEUE_DEPTH - 1)) ? '0 : ent.head + HW'(1);
	assign lim         = (LIMW'(cfg.qlimit) > LIMW'(QUEUE_DEPTH)) ?
	                     LIMW'(QUEUE_DEPTH) : LIMW'(cfg.qlimit);
	assign full        = LIMW'(ent.count) >= lim;

	// Checks in priority order: heading, speed, then room in the FIFO.
	always_comb begin
		if (bad_q) begin
			arr_status = ST_BAD_HEADING;
		end else if (fast_q) begin
			arr_status = ST_TOO_FAST;
		end else if (!in_range_q || full) begin
			arr_status = ST_QUEUE_FULL;
		end else begin
			arr_status = ST_QUEUED;
		end
	end

	// Elapsed time modulo 2^48; with a nonzero refill, anything from 2^16 up already fills any bucket.
	assign elapsed = now_q - ent.stamp;
	assign el_c    = (|elapsed[47:16]) ? 17'h10000 : {1'b0, elapsed[15:0]};
	assign tok     = level_q >= MILLI_PER_TOKEN;

	assign last_slot = (scan_q == SW'(SLOTS - 1));

	// Sequencer and memory control.
	always_comb begin
		state_d  = state_q;
		do_adv   = 1'b0;
		mac_ctl  = '0;
		mac_a    = '0;
		mac_b    = '0;
		cmp_x    = acc;
		cmp_y    = hold_q;
		sm_re    = 1'b0;
		sm_raddr = scan_q;
		sm_we    = 1'b0;
		sm_waddr = scan_q;
		sm_wdata = ent;
		q_re     = 1'b0;
		q_raddr  = AW'(scan_q) * AW'(QUEUE_DEPTH) + AW'(ent.head);
		q_we     = 1'b0;
		q_waddr  = AW'(slot_idx_q) * AW'(QUEUE_DEPTH) + AW'(pos);
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (command)
						CMD_ARRIVE: state_d = S_A_CHK;
						CMD_TICK:   state_d = S_T_RD;
						CMD_LEAVE: begin
							sm_we    = in_range_in;
							sm_waddr = SW'(slot);
							sm_wdata = '{bucket: cfg.burst, stamp: '0, head: '0, count: '0};
							state_d  = S_EMIT;
						end
						default: ;
					endcase
				end
			end
			S_A_CHK: begin
				case (step_q)
					STEP_HX: begin
						mac_ctl  = '{en: 1'b1, clr: 1'b1};
						mac_a    = hx_q;
						mac_b    = hx_q;
						sm_re    = 1'b1;
						sm_raddr = slot_idx_q;
					end
					STEP_HY: begin
						mac_ctl = '{en: 1'b1, clr: 1'b0};
						mac_a   = hy_q;
						mac_b   = hy_q;
					end
					STEP_HZ: begin
						mac_ctl = '{en: 1'b1, clr: 1'b0};
						mac_a   = hz_q;
						mac_b   = hz_q;
					end
					STEP_LO: begin
						mac_ctl = '{en: 1'b1, clr: 1'b1};
						mac_a   = lo_v;
						mac_b   = lo_v;
					end
					STEP_HI: begin
						mac_ctl = '{en: 1'b1, clr: 1'b1};
						mac_a   = hi_v;
						mac_b   = hi_v;
					end
					STEP_MS: begin
						cmp_x   = hold_q;
						cmp_y   = acc;
						mac_ctl = '{en: 1'b1, clr: 1'b1};
						mac_a   = ms_v;
						mac_b   = ms_v;
					end
					STEP_VX: begin
						mac_ctl = '{en: 1'b1, clr: 1'b1};
						mac_a   = vx_q;
						mac_b   = vx_q;
					end
					STEP_VY: begin
						mac_ctl = '{en: 1'b1, clr: 1'b0};
						mac_a   = vy_q;
						mac_b   = vy_q;
					end
					STEP_VZ: begin
						mac_ctl = '{en: 1'b1, clr: 1'b0};
						mac_a   = vz_q;
						mac_b   = vz_q;
					end
					default: state_d = S_A_DEC;
				endcase
			end
			S_A_DEC: begin
				if (arr_status == ST_QUEUED) begin
					q_we     = 1'b1;
					sm_we    = 1'b1;
					sm_waddr = slot_idx_q;
					sm_wdata = '{bucket: ent.bucket, stamp: ent.stamp, head: ent.head,
					             count: ent.count + CW'(1)};
				end
				state_d = S_EMIT;
			end
			S_T_RD: begin
				sm_re   = 1'b1;
				state_d = S_T_CHK;
			end
			S_T_CHK: begin
				if (ent.count == '0) begin
					do_adv = 1'b1;
				end else if (ent.stamp == '0) begin
					state_d = S_T_TOK;
				end else begin
					mac_ctl = '{en: 1'b1, clr: 1'b1};
					mac_a   = $signed(MAC_W'(ent.bucket));
					mac_b   = MAC_W'(1);
					state_d = S_T_REF;
				end
			end
			S_T_REF: begin
				mac_ctl = '{en: 1'b1, clr: 1'b0};
				mac_a   = $signed(MAC_W'(el_q));
				mac_b   = $signed(MAC_W'(cfg.refill));
				state_d = S_T_CLAMP;
			end
			S_T_CLAMP: begin
				cmp_y   = $signed(ACC_W'(cfg.burst));
				state_d = S_T_TOK;
			end
			S_T_TOK: begin
				sm_we    = 1'b1;
				sm_wdata = '{bucket: tok ? level_q - MILLI_PER_TOKEN : level_q,
				             stamp:  now_q,
				             head:   tok ? head_inc : ent.head,
				             count:  tok ? ent.count - CW'(1) : ent.count};
				if (tok) begin
					q_re    = 1'b1;
					state_d = S_EMIT;
				end else begin
					do_adv = 1'b1;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					if (res_last_q) begin
						state_d = S_IDLE;
					end else begin
						do_adv = 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
		// Moving on from a slot: next slot, or the closing beat after the last one.
		if (do_adv) begin
			state_d = last_slot ? S_EMIT : S_T_RD;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				step_q <= '0;
				scan_q <= '0;
			end else if (state_q == S_A_CHK) begin
				step_q <= step_q + 4'd1;
			end
			if (do_adv && !last_slot) begin
				scan_q <= scan_q + SW'(1);
			end
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Slot table valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q  <= '0;
			sm_rd_vld_q <= 1'b0;
		end else begin
			if (sm_we) begin
				slot_vld_q[sm_waddr] <= 1'b1;
			end
			if (sm_re) begin
				sm_rd_vld_q <= (SRW'(sm_raddr) < SRW'(SLOTS)) ? slot_vld_q[sm_raddr] : 1'b0;
			end
		end
	end

	// Slot table memory.
	always_ff @(posedge clk) begin
		if (sm_we) begin
			slot_mem[sm_waddr] <= sm_wdata;
		end
		if (sm_re) begin
			sm_rd_q <= slot_mem[sm_raddr];
		end
	end

	// FIFO store memory.
	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_waddr] <= ref_q;
		end
		if (q_re) begin
			q_rd_q <= q_mem[q_raddr];
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			slot_q <= slot;
			now_q  <= now_ms;
			ref_q  <= request_ref;
			hx_q   <= MAC_W'(heading_x);
			hy_q   <= MAC_W'(heading_y);
			hz_q   <= MAC_W'(heading_z);
			vx_q   <= MAC_W'(velocity_x);
			vy_q   <= MAC_W'(velocity_y);
			vz_q   <= MAC_W'(velocity_z);
			res_status_q <= ST_CLEARED;
			res_slot_q   <= slot;
			res_last_q   <= 1'b1;
		end
		if (state_q == S_A_CHK) begin
			case (step_q)
				STEP_LO:  hold_q <= acc;
				STEP_HI:  bad_q  <= cmp_gt;
				STEP_MS:  bad_q  <= bad_q | cmp_gt;
				STEP_VX:  hold_q <= acc;
				STEP_CMP: fast_q <= cmp_gt;
				default: ;
			endcase
		end
		if (state_q == S_A_DEC) begin
			res_status_q <= arr_status;
			res_slot_q   <= slot_q;
			res_last_q   <= 1'b1;
		end
		if (state_q == S_T_CHK) begin
			level_q <= ent.bucket;
			el_q    <= el_c;
		end
		if (state_q == S_T_CLAMP) begin
			level_q <= cmp_gt ? cfg.burst : acc[15:0];
		end
		if (state_q == S_T_TOK && tok) begin
			res_status_q <= ST_DISPATCHED;
			res_slot_q   <= SLOT_W'(scan_q);
			res_last_q   <= 1'b0;
		end
		if (do_adv && last_slot) begin
			res_status_q <= ST_TICK_DONE;
			res_slot_q   <= '0;
			res_last_q   <= 1'b1;
		end
		if (state_q == S_EMIT && out_free) begin
			status_q   <= res_status_q;
			out_slot_q <= res_slot_q;
			out_ref_q  <= (res_status_q == ST_DISPATCHED) ? q_rd_q : '0;
			last_q     <= res_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_slot  = out_slot_q;
	assign out_ref   = out_ref_q;
	assign last      = last_q;

endmodule

[src/stq_checker.sv]
// Port-level checker of the per-slot token bucket queue and its bind.
module stq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [stq_pkg::CMD_W-1:0]     command,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [stq_pkg::STATUS_W-1:0]  status,
	input logic [stq_pkg::SLOT_W-1:0]    out_slot,
	input logic [stq_pkg::REF_W-1:0]     out_ref,
	input logic                          last
);
	import stq_pkg::*;

	// A stalled result beat holds all of its fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_slot)
		&& $stable(out_ref) && $stable(last))
		else $error("stalled result beat changed");

	// Only a dispatch carries a handle.
	a_ref_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DISPATCHED |-> out_ref == '0)
		else $error("handle on a result that is not a dispatch");

	// The closing beat of a tick is the last one and names slot zero.
	a_tick_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_TICK_DONE |-> last && out_slot == '0)
		else $error("malformed tick done beat");

	// A dispatch is never the final beat of a tick.
	a_disp_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DISPATCHED |-> !last)
		else $error("dispatch marked as last");

	// A known command keeps the block busy on the following cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command != CMD_NONE |=> in_stall)
		else $error("input not stalled after taking a command");

endmodule

bind per_slot_token_bucket_queue stq_checker u_stq_checker (.*);

[sim/shaper_tb_pkg.sv]
`timescale 1ns / 1ps
// Beat types and the scoreboard class for the per-slot token bucket queue testbench.
package shaper_tb_pkg;
	import stq_pkg::*;

	// One input beat, field for field as on the ports.
	typedef struct {
		logic [CMD_W-1:0]        cmd;
		logic [SLOT_W-1:0]       slot;
		logic [TIME_W-1:0]       now;
		logic signed [HDG_W-1:0] hx;
		logic signed [HDG_W-1:0] hy;
		logic signed [HDG_W-1:0] hz;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic signed [VEL_W-1:0] vz;
		logic [REF_W-1:0]        req_ref;
	} req_beat_t;

	// One result beat.
	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [REF_W-1:0]    rref;
		logic                last;
	} res_beat_t;

	class shaper_scoreboard;
		// Shadow copy of the configuration registers.
		logic [15:0] burst;
		logic [9:0]  refill;
		logic [4:0]  qlimit;
		logic [15:0] max_speed;
		logic [12:0] tol;

		// Shadow copy of the per-slot buckets and FIFOs.
		logic [15:0]      level [SLOTS_DEF];
		logic [TIME_W-1:0] stamp [SLOTS_DEF];
		logic [REF_W-1:0] fifo  [SLOTS_DEF][QUEUE_DEPTH_DEF];
		int unsigned      head  [SLOTS_DEF];
		int unsigned      count [SLOTS_DEF];

		// Result beats that are owed by the block, oldest first.
		res_beat_t   pending_outcomes[$];
		int unsigned failures;

		function new();
			burst     = BURST_RESET;
			refill    = REFILL_RESET;
			qlimit    = QLIMIT_RESET;
			max_speed = MAX_SPEED_RESET;
			tol       = TOL_RESET;
			failures  = 0;
			for (int s = 0; s < SLOTS_DEF; s++) begin
				empty_slot(s);
			end
		endfunction

		// A cleared slot has a full bucket, no stamp and an empty FIFO.
		function void empty_slot(int s);
			level[s] = burst;
			stamp[s] = '0;
			head[s]  = 0;
			count[s] = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_BURST:     burst     = data;
				CFG_REFILL:    refill    = data[9:0];
				CFG_QLIMIT:    qlimit    = data[4:0];
				CFG_MAX_SPEED: max_speed = data;
				CFG_TOL:       tol       = data[12:0];
				default: ;
			endcase
		endfunction

		// Refill the bucket by the elapsed time (unless never stamped), then try to spend a token.
		function bit spend_token(int s, logic [TIME_W-1:0] now);
			logic [TIME_W-1:0] gap;
			longint unsigned   fill;
			if (stamp[s] != '0) begin
				gap  = now - stamp[s];
				fill = level[s];
				fill = fill + gap * refill;
				level[s] = (fill < burst) ? fill[15:0] : burst;
			end
			stamp[s] = now;
			if (level[s] < MILLI_PER_TOKEN) begin
				return 1'b0;
			end
			level[s] = level[s] - MILLI_PER_TOKEN;
			return 1'b1;
		endfunction

		function void add_outcome(logic [STATUS_W-1:0] st, int s, logic [REF_W-1:0] r,
				logic fin);
			res_beat_t o;
			o.status = st;
			o.slot   = SLOT_W'(s);
			o.rref   = r;
			o.last   = fin;
			pending_outcomes.insert(pending_outcomes.size(), o);
		endfunction

		// Work out the result beats that an accepted input beat causes.
		function void note_request(req_beat_t b);
			longint hs, vs, lo, hi, spd;
			int     s, lim, pos;
			s = b.slot;
			case (b.cmd)
				CMD_ARRIVE: begin
					hs  = longint'(b.hx) * b.hx + longint'(b.hy) * b.hy + longint'(b.hz) * b.hz;
					vs  = longint'(b.vx) * b.vx + longint'(b.vy) * b.vy + longint'(b.vz) * b.vz;
					lo  = longint'(UNIT_Q14) - longint'(tol);
					hi  = longint'(UNIT_Q14) + longint'(tol);
					spd = longint'(max_speed);
					lim = (qlimit < QUEUE_DEPTH_DEF) ? int'(qlimit) : QUEUE_DEPTH_DEF;
					if (hs < lo * lo || hs > hi * hi) begin
						add_outcome(ST_BAD_HEADING, s, '0, 1'b1);
					end else if (vs > spd * spd) begin
						add_outcome(ST_TOO_FAST, s, '0, 1'b1);
					end else if (count[s] >= lim) begin
						add_outcome(ST_QUEUE_FULL, s, '0, 1'b1);
					end else begin
						pos = (head[s] + count[s]) % QUEUE_DEPTH_DEF;
						fifo[s][pos] = b.req_ref;
						count[s]++;
						add_outcome(ST_QUEUED, s, '0, 1'b1);
					end
				end
				CMD_TICK: begin
					for (int t = 0; t < SLOTS_DEF; t++) begin
						if (count[t] != 0 && spend_token(t, b.now)) begin
							add_outcome(ST_DISPATCHED, t, fifo[t][head[t]], 1'b0);
							head[t] = (head[t] + 1) % QUEUE_DEPTH_DEF;
							count[t]--;
						end
					end
					add_outcome(ST_TICK_DONE, 0, '0, 1'b1);
				end
				CMD_LEAVE: begin
					empty_slot(s);
					add_outcome(ST_CLEARED, s, '0, 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s wrong, expected %0h, actual %0h", $time, name, want, got);
				failures++;
			end
		endfunction

		// Compare a result beat with the oldest owed one.
		function void check_outcome(res_beat_t got);
			res_beat_t want;
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual status %0h slot %0h ref %0h last %0h",
					$time, got.status, got.slot, got.rref, got.last);
				failures++;
				return;
			end
			want = pending_outcomes[0];
			pending_outcomes.delete(0);
			compare_field("status", want.status, got.status);
			compare_field("out_slot", want.slot, got.slot);
			compare_field("out_ref", want.rref, got.rref);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

endpackage

[sim/testbench.sv]
`timescale 1ns / 1ps
// Top of the per-slot token bucket queue testbench: clock, reset, beat drivers and stimulus.
module testbench;
	import stq_pkg::*;
	import shaper_tb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES   = 400;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index   = '0;
	logic [CFG_DATA_W-1:0]   cfg_data    = '0;
	logic                    in_valid    = 1'b0;
	logic                    in_stall;
	logic [CMD_W-1:0]        command     = '0;
	logic [SLOT_W-1:0]       slot        = '0;
	logic [TIME_W-1:0]       now_ms      = '0;
	logic signed [HDG_W-1:0] heading_x   = '0;
	logic signed [HDG_W-1:0] heading_y   = '0;
	logic signed [HDG_W-1:0] heading_z   = '0;
	logic signed [VEL_W-1:0] velocity_x  = '0;
	logic signed [VEL_W-1:0] velocity_y  = '0;
	logic signed [VEL_W-1:0] velocity_z  = '0;
	logic [REF_W-1:0]        request_ref = '0;
	logic                    out_valid;
	logic                    out_stall   = 1'b0;
	logic [STATUS_W-1:0]     status;
	logic [SLOT_W-1:0]       out_slot;
	logic [REF_W-1:0]        out_ref;
	logic                    last;

	// Shared between the stimulus and the result side.
	bit                calm         = 1'b0;
	bit                hold_request = 1'b0;
	logic [TIME_W-1:0] clock_ms     = 48'd1;

	shaper_scoreboard sb = new();

	per_slot_token_bucket_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.slot        (slot),
		.now_ms      (now_ms),
		.heading_x   (heading_x),
		.heading_y   (heading_y),
		.heading_z   (heading_z),
		.velocity_x  (velocity_x),
		.velocity_y  (velocity_y),
		.velocity_z  (velocity_z),
		.request_ref (request_ref),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_slot    (out_slot),
		.out_ref     (out_ref),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one input beat, with random idle cycles before it, and note it once taken.
	task automatic send_request(req_beat_t b);
		while (!calm && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		command     <= b.cmd;
		slot        <= b.slot;
		now_ms      <= b.now;
		heading_x   <= b.hx;
		heading_y   <= b.hy;
		heading_z   <= b.hz;
		velocity_x  <= b.vx;
		velocity_y  <= b.vy;
		velocity_z  <= b.vz;
		request_ref <= b.req_ref;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_request(b);
	endtask

	task automatic send_arrive(int s, int hx, int hy, int hz, int vx, int vy, int vz,
			logic [REF_W-1:0] r);
		req_beat_t b;
		b.cmd     = CMD_ARRIVE;
		b.slot    = SLOT_W'(s);
		b.now     = {16'($urandom), 32'($urandom)};
		b.hx      = HDG_W'(hx);
		b.hy      = HDG_W'(hy);
		b.hz      = HDG_W'(hz);
		b.vx      = VEL_W'(vx);
		b.vy      = VEL_W'(vy);
		b.vz      = VEL_W'(vz);
		b.req_ref = r;
		send_request(b);
	endtask

	// A tick, leave or unknown command; the fields it ignores carry noise.
	task automatic send_command(logic [CMD_W-1:0] c, int s, logic [TIME_W-1:0] t);
		req_beat_t b;
		b.cmd     = c;
		b.slot    = SLOT_W'(s);
		b.now     = t;
		b.hx      = HDG_W'($urandom);
		b.hy      = HDG_W'($urandom);
		b.hz      = HDG_W'($urandom);
		b.vx      = VEL_W'($urandom);
		b.vy      = VEL_W'($urandom);
		b.vz      = VEL_W'($urandom);
		b.req_ref = $urandom;
		send_request(b);
	endtask

	// Stop offering, wait for every owed beat, then let any silent work finish.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_outcomes.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic write_settings(logic [15:0] burst_v, logic [15:0] refill_v,
			logic [15:0] qlimit_v, logic [15:0] speed_v, logic [15:0] tol_v);
		write_reg(CFG_BURST, burst_v);
		write_reg(CFG_REFILL, refill_v);
		write_reg(CFG_QLIMIT, qlimit_v);
		write_reg(CFG_MAX_SPEED, speed_v);
		write_reg(CFG_TOL, tol_v);
		cfg_we <= 1'b0;
	endtask

	// Random input beat: mostly well-formed arrivals and ticks, some noise.
	function automatic req_beat_t make_item(int span);
		req_beat_t b;
		int        pick, a, c, d, lim, m;
		real       rest;
		b.cmd     = CMD_ARRIVE;
		b.slot    = SLOT_W'($urandom_range(0, span));
		b.now     = {16'($urandom), 32'($urandom)};
		b.hx      = HDG_W'($urandom);
		b.hy      = HDG_W'($urandom);
		b.hz      = HDG_W'($urandom);
		b.vx      = VEL_W'($urandom);
		b.vy      = VEL_W'($urandom);
		b.vz      = VEL_W'($urandom);
		b.req_ref = $urandom;
		pick      = $urandom_range(0, 99);
		if (pick < 52) begin
			// Unit heading: along one axis, or two random components and the third solved.
			if ($urandom_range(0, 3) == 0) begin
				a    = $urandom_range(0, 1) ? -16384 : 16384;
				b.hx = '0;
				b.hy = '0;
				b.hz = '0;
				case ($urandom_range(0, 2))
					0: begin
						b.hx = HDG_W'(a);
					end
					1: begin
						b.hy = HDG_W'(a);
					end
					default: begin
						b.hz = HDG_W'(a);
					end
				endcase
			end else begin
				a    = int'($urandom_range(0, 32768)) - 16384;
				rest = 268435456.0 - real'(a * a);
				lim  = $rtoi($sqrt(rest));
				c    = int'($urandom_range(0, 2 * lim)) - lim;
				d    = $rtoi($sqrt(rest - real'(c * c)) + 0.5);
				b.hx = HDG_W'(a);
				b.hy = HDG_W'(c);
				b.hz = HDG_W'($urandom_range(0, 1) ? -d : d);
			end
			// Each component within half the limit keeps the speed legal.
			m    = int'(sb.max_speed) / 2;
			b.vx = VEL_W'(int'($urandom_range(0, 2 * m)) - m);
			b.vy = VEL_W'(int'($urandom_range(0, 2 * m)) - m);
			b.vz = VEL_W'(int'($urandom_range(0, 2 * m)) - m);
		end else if (pick < 62) begin
			// A malformed arrival keeps its fully random fields.
		end else if (pick < 87) begin
			// Time mostly runs forward; now and then it jumps anywhere, backwards too.
			b.cmd = CMD_TICK;
			if ($urandom_range(0, 9) == 0) begin
				clock_ms = {16'($urandom), 32'($urandom)};
			end else begin
				clock_ms = clock_ms + $urandom_range(0, 1500);
			end
			b.now = clock_ms;
		end else if (pick < 95) begin
			b.cmd = CMD_LEAVE;
		end else begin
			b.cmd = CMD_NONE;
		end
		return b;
	endfunction

	task automatic run_phase(int items, int span);
		repeat (items) send_request(make_item(span));
		settle();
	endtask

	// Result side: check every beat taken, stall at random or for one long hold.
	initial begin : result_side
		int        hold_left;
		res_beat_t got;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.status = status;
				got.slot   = out_slot;
				got.rref   = out_ref;
				got.last   = last;
				sb.check_outcome(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 19);
			end
		end
	end

	// Guard against a hang.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Heading bounds, speed limit and field extremes with the reset settings.
		send_arrive(0, 16384, 0, 0, 0, 0, 0, 32'h1111_1111);
		send_arrive(15, 16220, 0, 0, 4000, 0, 0, 32'hFFFF_FFFF);
		send_arrive(1, 0, 0, 16548, 0, -4000, 0, 32'h0000_0001);
		send_arrive(2, 16219, 0, 0, 0, 0, 0, 32'h2222_2222);
		send_arrive(2, 0, 16549, 0, 0, 0, 0, 32'h3333_3333);
		send_arrive(2, 0, 0, -16384, 4001, 0, 0, 32'h4444_4444);
		send_arrive(5, -32768, -32768, -32768, 0, 0, 0, 32'h5555_5555);
		send_arrive(6, 32767, 32767, 32767, 0, 0, 0, 32'h6666_6666);
		send_arrive(7, 0, 16384, 0, -65536, -65536, -65536, 32'h7777_7777);
		send_arrive(8, 0, 0, -16384, 65535, 65535, 65535, 32'h8888_8888);

		// A tick at time zero leaves the stamp unset; then refill, empty bucket, time backwards.
		send_command(CMD_TICK, 0, 48'd0);
		send_command(CMD_TICK, 0, 48'd5);
		repeat (3) send_arrive(0, -16384, 0, 0, 0, 0, 0, $urandom);
		send_command(CMD_TICK, 0, 48'd100);
		send_command(CMD_TICK, 0, 48'd100);
		send_command(CMD_TICK, 0, 48'd50);
		send_command(CMD_LEAVE, 0, 48'd0);
		send_command(CMD_NONE, 3, 48'd0);
		send_command(CMD_LEAVE, 7, 48'd0);
		settle();

		// A queue limit of zero refuses everything; a limit of one fills at once.
		write_settings(16'd3000, 16'd3, 16'd0, 16'd4000, 16'd164);
		send_arrive(4, 16384, 0, 0, 0, 0, 0, 32'h9999_9999);
		settle();
		write_settings(16'd3000, 16'd3, 16'd1, 16'd4000, 16'd164);
		send_arrive(4, 0, 16384, 0, 0, 0, 0, 32'hAAAA_AAAA);
		send_arrive(4, 0, 16384, 0, 0, 0, 0, 32'hBBBB_BBBB);
		send_command(CMD_TICK, 0, 48'd2000);
		settle();

		// Random phases over several settings; the first one meets a long receiver hold.
		write_settings(16'd3000, 16'd3, 16'd10, 16'd4000, 16'd164);
		hold_request = 1'b1;
		run_phase(16, 3);
		write_settings(16'd65535, 16'd1000, 16'd16, 16'd65535, 16'd8191);
		calm = 1'b1;
		run_phase(16, 15);
		calm = 1'b0;
		// The burst drops below the levels reached before, with no refill.
		write_settings(16'd1000, 16'd0, 16'd1, 16'd0, 16'd0);
		run_phase(16, 2);
		write_settings(16'd2000, 16'd1023, 16'd31, 16'd30000, 16'd1000);
		run_phase(16, 15);
		write_settings(16'($urandom_range(1000, 65535)), 16'($urandom_range(0, 1000)),
			16'($urandom_range(1, 16)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 8191)));
		run_phase(16, 7);
		write_settings(16'd3000, 16'd5, 16'd2, 16'd4000, 16'd164);
		run_phase(16, 1);

		if (sb.failures == 0 && sb.pending_outcomes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[per_slot_token_bucket_queue.f]
src/stq_pkg.sv
src/stq_cfg.sv
src/stq_mac.sv
src/per_slot_token_bucket_queue.sv
src/stq_checker.sv
sim/shaper_tb_pkg.sv
sim/testbench.sv
